// ----- design/lbfg_pkg.sv -----
// Shared types and constants for the LED bar frame generator.
// Holds item structs, command and register codes, and the duration helper.
// No dependencies.
package lbfg_pkg;

    localparam int CMD_W     = 2;
    localparam int VALUE_W   = 4;
    localparam int TIMER_W   = 10;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DW    = 10;

    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SINGLE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LEVEL  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LATCH_HIGH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAP         = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [VALUE_W-1:0] led_value;
        logic               lit;
        logic               forward;
    } in_item_t;

    typedef struct packed {
        logic clock_level;
        logic data_level;
        logic busy_res;
        logic rejected;
    } out_item_t;

    // Frame request latched at start.
    typedef struct packed {
        logic               level_mode;
        logic [VALUE_W-1:0] value;
        logic               lit;
        logic               forward;
    } frame_req_t;

    // Data pin actions at a slot clock rise.
    typedef struct packed {
        logic set_data;
        logic clr_data;
    } slot_act_t;

    // Zero duration counts as one tick.
    function automatic logic [TIMER_W-1:0] dur(input logic [TIMER_W-1:0] v);
        return (v == '0) ? TIMER_W'(1) : v;
    endfunction

endpackage

// ----- design/led_bar_frame_generator.sv -----
// LED bar frame generator top level: command decode, waveform sequencer,
// configuration registers and result register.
// Depends on lbfg_pkg and lbfg_slot_decode.
// An item's result is registered at the edge that accepts it.
// Throughput: one item per cycle, set by the single-pass next-state logic, unless a held result stalls it.
// Input stays open while the result register drains (s_ready = !m_valid || m_ready).
// Reset (aresetn low, synchronous): idle, clock and data pins low, registers at
// 9/14/4/240 ticks, result register empty. No clearing pass.
module led_bar_frame_generator
    import lbfg_pkg::*;
#(
    parameter int LED_SLOTS       = 10,
    parameter int BITS_PER_SLOT   = 8,
    parameter int PREAMBLE_PULSES = 11,
    parameter int TAIL_PULSES     = 12
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // item input
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_data,
    // result output
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_data,
    // configuration writes
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DW-1:0]    cfg_wdata
);

    localparam int DATA_PULSES = 4;
    localparam int SLOT_PULSES = LED_SLOTS * BITS_PER_SLOT;
    localparam int MAX_A  = (SLOT_PULSES > PREAMBLE_PULSES) ? SLOT_PULSES : PREAMBLE_PULSES;
    localparam int MAX_B  = (TAIL_PULSES > DATA_PULSES) ? TAIL_PULSES : DATA_PULSES;
    localparam int MAX_P  = (MAX_A > MAX_B) ? MAX_A : MAX_B;
    localparam int PIDX_W = $clog2(MAX_P + 1);

    // Sequencer phases
    localparam logic [3:0] PH_IDLE      = 4'd0;
    localparam logic [3:0] PH_PRE       = 4'd1;
    localparam logic [3:0] PH_SLOT      = 4'd2;
    localparam logic [3:0] PH_TAIL      = 4'd3;
    localparam logic [3:0] PH_LATCH_HI  = 4'd4;
    localparam logic [3:0] PH_LATCH_LO  = 4'd5;
    localparam logic [3:0] PH_LATCH_HI2 = 4'd6;
    localparam logic [3:0] PH_GAP       = 4'd7;
    localparam logic [3:0] PH_DPULSE    = 4'd8;
    localparam logic [3:0] PH_FINAL     = 4'd9;

    // Configuration registers
    logic [7:0]         half_reg;
    logic [7:0]         latch_reg;
    logic [7:0]         short_reg;
    logic [TIMER_W-1:0] gap_reg;

    // Sequencer state
    logic [3:0]         phase_reg,  phase_next;
    logic [PIDX_W-1:0]  pidx_reg,   pidx_next;
    logic               high_reg,   high_next;
    logic [TIMER_W-1:0] timer_reg,  timer_next;
    frame_req_t         req_reg,    req_next;
    logic               clock_reg,  clock_next;
    logic               data_reg,   data_next;

    // Result register
    logic               m_valid_reg;
    out_item_t          m_data_reg, m_data_next;

    logic               s_fire;
    logic               is_start;
    logic [TIMER_W-1:0] t_dec;
    logic [PIDX_W-1:0]  pidx_inc;
    logic [PIDX_W-1:0]  train_count;
    logic [3:0]         train_after;
    logic               rise;
    logic [3:0]         rise_phase;
    logic [PIDX_W-1:0]  rise_idx;
    logic               rej;
    slot_act_t          slot_act;

    assign s_ready  = !m_valid_reg || m_ready;
    assign s_fire   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign is_start = (s_data.command == CMD_SINGLE) || (s_data.command == CMD_LEVEL);
    assign t_dec    = (timer_reg != '0) ? (timer_reg - TIMER_W'(1)) : '0;
    assign pidx_inc = pidx_reg + PIDX_W'(1);

    // pulse count and successor of the current clock train
    always_comb begin
        case (phase_reg)
            PH_PRE: begin
                train_count = PIDX_W'(PREAMBLE_PULSES);
                train_after = PH_SLOT;
            end
            PH_SLOT: begin
                train_count = PIDX_W'(SLOT_PULSES);
                train_after = PH_TAIL;
            end
            default: begin
                train_count = PIDX_W'(TAIL_PULSES);
                train_after = PH_LATCH_HI;
            end
        endcase
    end

    // data pin decision for the clock rise being started
    lbfg_slot_decode #(
        .LED_SLOTS    (LED_SLOTS),
        .BITS_PER_SLOT(BITS_PER_SLOT),
        .PIDX_W       (PIDX_W)
    ) u_slot_decode (
        .pulse_idx(rise_idx),
        .req      (req_reg),
        .act      (slot_act)
    );

    // Next state for one item
    always_comb begin
        phase_next = phase_reg;
        pidx_next  = pidx_reg;
        high_next  = high_reg;
        timer_next = timer_reg;
        req_next   = req_reg;
        clock_next = clock_reg;
        data_next  = data_reg;
        rise       = 1'b0;
        rise_phase = phase_reg;
        rise_idx   = pidx_reg;
        rej        = 1'b0;

        if (is_start) begin
            if (phase_reg != PH_IDLE) begin
                rej = 1'b1;                 // frame in flight: ignore, flag
            end else begin
                req_next.level_mode = (s_data.command == CMD_LEVEL);
                req_next.value      = s_data.led_value;
                req_next.lit        = s_data.lit;
                req_next.forward    = s_data.forward;
                phase_next          = PH_PRE;
                pidx_next           = '0;
                rise                = 1'b1;
                rise_phase          = PH_PRE;
                rise_idx            = '0;
            end
        end else if (phase_reg != PH_IDLE) begin
            timer_next = t_dec;
            if (t_dec == '0) begin
                case (phase_reg)
                    PH_PRE, PH_SLOT, PH_TAIL: begin
                        if (high_reg) begin
                            clock_next = 1'b0;
                            high_next  = 1'b0;
                            timer_next = dur(TIMER_W'(half_reg));
                        end else if (pidx_inc >= train_count) begin
                            phase_next = train_after;
                            pidx_next  = '0;
                            if (train_after == PH_LATCH_HI) begin
                                clock_next = 1'b1;
                                timer_next = dur(TIMER_W'(latch_reg));
                            end else begin
                                rise       = 1'b1;
                                rise_phase = train_after;
                                rise_idx   = '0;
                            end
                        end else begin
                            pidx_next = pidx_inc;
                            rise      = 1'b1;
                            rise_idx  = pidx_inc;
                        end
                    end
                    PH_LATCH_HI: begin
                        phase_next = PH_LATCH_LO;
                        clock_next = 1'b0;
                        timer_next = dur(TIMER_W'(short_reg));
                    end
                    PH_LATCH_LO: begin
                        phase_next = PH_LATCH_HI2;
                        clock_next = 1'b1;
                        timer_next = dur(TIMER_W'(short_reg));
                    end
                    PH_LATCH_HI2: begin
                        phase_next = PH_GAP;
                        clock_next = 1'b0;
                        timer_next = dur(gap_reg);
                    end
                    PH_GAP: begin
                        phase_next = PH_DPULSE;
                        pidx_next  = '0;
                        high_next  = 1'b1;
                        data_next  = 1'b1;
                        timer_next = dur(TIMER_W'(short_reg));
                    end
                    PH_DPULSE: begin
                        // data pulses with clock held low
                        if (high_reg) begin
                            high_next  = 1'b0;
                            data_next  = 1'b0;
                            timer_next = dur(TIMER_W'(short_reg));
                        end else if (pidx_inc < PIDX_W'(DATA_PULSES)) begin
                            pidx_next  = pidx_inc;
                            high_next  = 1'b1;
                            data_next  = 1'b1;
                            timer_next = dur(TIMER_W'(short_reg));
                        end else begin
                            phase_next = PH_FINAL;
                            pidx_next  = '0;
                            clock_next = 1'b1;
                            timer_next = dur(TIMER_W'(short_reg));
                        end
                    end
                    PH_FINAL: begin
                        phase_next = PH_IDLE;
                        clock_next = 1'b0;
                        timer_next = '0;
                        high_next  = 1'b0;
                    end
                    default: begin
                        phase_next = PH_IDLE;
                        timer_next = '0;
                    end
                endcase
            end
        end

        // common clock rise of the pulse trains
        if (rise) begin
            clock_next = 1'b1;
            high_next  = 1'b1;
            timer_next = dur(TIMER_W'(half_reg));
            if (rise_phase == PH_SLOT) begin
                if (slot_act.set_data) begin
                    data_next = 1'b1;
                end
                if (slot_act.clr_data) begin
                    data_next = 1'b0;
                end
            end
        end

        // a start shows its new levels; a tick shows the levels it spans
        m_data_next.clock_level = is_start ? clock_next : clock_reg;
        m_data_next.data_level  = is_start ? data_next  : data_reg;
        m_data_next.busy_res    = (phase_next != PH_IDLE);
        m_data_next.rejected    = rej;
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_reg  <= 8'd9;
            latch_reg <= 8'd14;
            short_reg <= 8'd4;
            gap_reg   <= TIMER_W'(240);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_HALF_PERIOD: half_reg  <= cfg_wdata[7:0];
                REG_LATCH_HIGH:  latch_reg <= cfg_wdata[7:0];
                REG_SHORT:       short_reg <= cfg_wdata[7:0];
                REG_GAP:         gap_reg   <= cfg_wdata[TIMER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Sequencer state, advanced once per accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            pidx_reg  <= '0;
            high_reg  <= 1'b0;
            timer_reg <= '0;
            clock_reg <= 1'b0;
            data_reg  <= 1'b0;
        end else if (s_fire) begin
            phase_reg <= phase_next;
            pidx_reg  <= pidx_next;
            high_reg  <= high_next;
            timer_reg <= timer_next;
            clock_reg <= clock_next;
            data_reg  <= data_next;
        end
    end

    // Latched request: payload, no reset
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            req_reg <= req_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_data_reg <= m_data_next;
        end
    end

    // Checks
    a_reject_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && is_start && (phase_reg != PH_IDLE)) |=> m_data_reg.rejected)
        else $error("start while busy not flagged");

    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_IDLE) |-> (!clock_reg && (timer_reg == '0)))
        else $error("idle with clock high or timer running");

    a_hold_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && !is_start && (phase_reg != PH_IDLE) && (timer_reg > TIMER_W'(1)))
        |=> (phase_reg == $past(phase_reg)))
        else $error("phase left before its timer ran out");

    a_train_high: assert property (@(posedge aclk) disable iff (!aresetn)
        (((phase_reg == PH_PRE) || (phase_reg == PH_SLOT) || (phase_reg == PH_TAIL))
         && high_reg) |-> clock_reg)
        else $error("train high half with clock low");

endmodule

// ----- design/lbfg_slot_decode.sv -----
// Slot decoder: compares a slot-train pulse index against each slot's rise and
// fall bit and decides whether the data pin rises or falls at that clock rise.
// Depends on lbfg_pkg.
module lbfg_slot_decode
    import lbfg_pkg::*;
#(
    parameter int LED_SLOTS     = 10,
    parameter int BITS_PER_SLOT = 8,
    parameter int PIDX_W        = 7
) (
    input  logic [PIDX_W-1:0] pulse_idx,
    input  frame_req_t        req,
    output slot_act_t         act
);

    localparam int CMP_W    = VALUE_W + 1;
    localparam int RISE_BIT = 0;
    localparam int FALL_BIT = 4;

    logic [CMP_W-1:0]     value_w;
    logic [LED_SLOTS-1:0] slot_match;

    assign value_w = {1'b0, req.value};

    // per-slot selection; reverse fill counts from the last slot
    always_comb begin
        for (int s = 0; s < LED_SLOTS; s++) begin
            slot_match[s] = !req.level_mode ? (value_w == CMP_W'(s + 1))
                          : req.forward     ? (CMP_W'(s) < value_w)
                          : (CMP_W'(LED_SLOTS - 1 - s) < value_w);
        end
    end

    // pulse index of each slot's rise and fall bit is a constant
    always_comb begin
        act.set_data = 1'b0;
        act.clr_data = 1'b0;
        for (int s = 0; s < LED_SLOTS; s++) begin
            if (pulse_idx == PIDX_W'(s * BITS_PER_SLOT + RISE_BIT)) begin
                act.set_data = slot_match[s] && (req.level_mode || req.lit);
            end
            if (pulse_idx == PIDX_W'(s * BITS_PER_SLOT + FALL_BIT)) begin
                act.clr_data = slot_match[s];
            end
        end
    end

endmodule
